// ===== sv/cpnt_pkg.sv =====
// Package with shared constants, types and the CORDIC arctangent table for the PLL tracker.
package cpnt_pkg;

  localparam int CordicMaxStages = 24;

  // Microrotation operating modes of the shared CORDIC unit.
  localparam logic MODE_ROTATE = 1'b0;
  localparam logic MODE_VECTOR = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_COEF   = 2'd0;
  localparam logic [1:0] REG_CENTER = 2'd1;
  localparam logic [1:0] REG_LOW    = 2'd2;
  localparam logic [1:0] REG_HIGH   = 2'd3;

  // Start vector of the rotation pass, 0.60725 in Q30.
  localparam logic signed [39:0] CordicGain = 40'sd652032874;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [31:0] atan_turns32(input logic [4:0] i);
    logic [31:0] t;
    unique case (i)
      5'd0: t = 32'd536870912;
      5'd1: t = 32'd316933406;
      5'd2: t = 32'd167458907;
      5'd3: t = 32'd85004756;
      5'd4: t = 32'd42667331;
      5'd5: t = 32'd21354465;
      5'd6: t = 32'd10679838;
      5'd7: t = 32'd5340245;
      5'd8: t = 32'd2670163;
      5'd9: t = 32'd1335087;
      5'd10: t = 32'd667544;
      5'd11: t = 32'd333772;
      5'd12: t = 32'd166886;
      5'd13: t = 32'd83443;
      5'd14: t = 32'd41722;
      5'd15: t = 32'd20861;
      5'd16: t = 32'd10430;
      5'd17: t = 32'd5215;
      5'd18: t = 32'd2608;
      5'd19: t = 32'd1304;
      5'd20: t = 32'd652;
      5'd21: t = 32'd326;
      5'd22: t = 32'd163;
      5'd23: t = 32'd81;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

  // Control bundle from the sequencer to the CORDIC unit.
  typedef struct packed {
    logic       load;
    logic       step;
    logic       mode;
    logic [4:0] index;
  } cordic_ctl_t;

endpackage

// ===== sv/complex_pll_nco_tracker.sv =====
// Top level of the complex PLL with NCO: sequencer, loop filter and stream ports.
// Usage: one complex sample word enters on s_axis (tdata = sample_i, sample_q).
// The block mixes it with the conjugate NCO, measures the phase error with a
// vectoring CORDIC, filters the phase step, advances the phase and computes
// the new NCO value with a rotation CORDIC, then presents one result word on
// m_axis. One shared CORDIC unit does all three passes in order: the NCO at
// the stored phase, the arctangent and the NCO at the new phase.
// One word is processed at a time, and the block is ready for the next word in
// the cycle after the result is loaded. The length of the three CORDIC passes
// sets the rate at which words are taken. s_axis_tready is low while a word is
// in work. The result sits in an output register; a stalled receiver holds it
// there, and the next word is taken while it waits, but its result waits for
// the register to empty. Configuration writes (cfg_we, cfg_index, cfg_data)
// take effect at once; the user must make them while the block is idle, which
// the block does not enforce. Writing center_increment also loads the running
// step. Synchronous reset restores register defaults, zeroes the phase and the
// running step, and empties the output register.
module complex_pll_nco_tracker #(
  parameter int CORDIC_STAGES = 18,
  parameter int PHASE_BITS    = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // sample_i[15:0], sample_q[31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [111:0] m_axis_tdata, // mixed_i, mixed_q, phase_error, step_now, nco_cos, nco_sin
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int PB = PHASE_BITS;
  localparam int CmpW = (PB > 24) ? PB : 24;
  localparam int Stages = (CORDIC_STAGES < cpnt_pkg::CordicMaxStages) ?
                          CORDIC_STAGES : cpnt_pkg::CordicMaxStages;
  localparam logic [4:0] LastStage = 5'(Stages - 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_NCO1   = 4'd1;
  localparam logic [3:0] ST_MIX    = 4'd2;
  localparam logic [3:0] ST_ALOAD  = 4'd3;
  localparam logic [3:0] ST_ATAN   = 4'd4;
  localparam logic [3:0] ST_FILT1  = 4'd5;
  localparam logic [3:0] ST_FILT2  = 4'd6;
  localparam logic [3:0] ST_LIMIT  = 4'd7;
  localparam logic [3:0] ST_NCO2   = 4'd8;
  localparam logic [3:0] ST_SCALE  = 4'd9;
  localparam logic [3:0] ST_DONE   = 4'd10;
  localparam logic [3:0] ST_SCALE1 = 4'd11;
  localparam logic [3:0] ST_MIX2   = 4'd12;

  logic [3:0] state;
  logic [4:0] cnt;

  logic [15:0]         coef;
  logic signed [23:0]  center, low_lim, high_lim;
  logic signed [PB-1:0] angle, run_step;

  logic signed [15:0] si, sq;
  logic signed [16:0] c, s;
  logic               fold_neg;
  logic signed [33:0] pi_, pq;
  logic signed [33:0] p_a, p_b, p_c, p_d;
  logic signed [PB-1:0] err, a_z0;
  logic signed [57:0] acc_a, acc_b;
  logic signed [PB-1:0] step_f;

  logic        out_valid;
  logic [111:0] out_data;

  cpnt_pkg::cordic_ctl_t ctl;
  logic signed [39:0] x_load, y_load, cx, cy;
  logic signed [PB-1:0] z_load, cz;

  cpnt_cordic #(.PHASE_BITS(PB)) u_cordic (
    .clk(clk), .ctl(ctl), .x_load(x_load), .y_load(y_load), .z_load(z_load),
    .x(cx), .y(cy), .z(cz)
  );

  localparam logic signed [PB-1:0] Quarter = PB'(1) <<< (PB - 2);
  localparam logic signed [PB-1:0] Half    = PB'(1) <<< (PB - 1);

  logic signed [PB-1:0] limited;

  // Angle folding for the rotation pass.
  logic signed [PB-1:0] nco_src, fold_a;
  logic                 fold_n;
  always_comb begin
    nco_src = (state == ST_LIMIT) ? angle + limited : angle;
    fold_n  = 1'b0;
    fold_a  = nco_src;
    if (nco_src > Quarter) begin
      fold_a = nco_src - Half;
      fold_n = 1'b1;
    end else if (nco_src < -Quarter) begin
      fold_a = nco_src + Half;
      fold_n = 1'b1;
    end
  end

  // Q30 to Q15 scaling with clamp.
  function automatic logic signed [16:0] scale_q15(input logic signed [39:0] v,
                                                   input logic neg);
    logic signed [56:0] p;
    logic signed [56:0] r;
    logic signed [16:0] q;
    p = 57'(v) * 57'sd32767 + (57'sd1 <<< 29);
    r = p >>> 30;
    if (r > 57'sd32767) q = 17'sd32767;
    else if (r < -57'sd32767) q = -17'sd32767;
    else q = 17'(r);
    return neg ? -q : q;
  endfunction

  function automatic logic [15:0] round_sat16(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd16384) >>> 15;
    if (r > 34'sd32767) return 16'h7fff;
    if (r < -34'sd32768) return 16'h8000;
    return r[15:0];
  endfunction

  logic vec_neg;
  always_comb begin
    vec_neg = pi_[33];
    a_z0 = '0;
    x_load = '0;
    y_load = '0;
    z_load = fold_a;
    ctl = '0;
    ctl.index = cnt;
    unique case (state)
      ST_IDLE: begin
        ctl.load = s_axis_tvalid && s_axis_tready;
        x_load = cpnt_pkg::CordicGain;
      end
      ST_LIMIT: begin
        ctl.load = 1'b1;
        x_load = cpnt_pkg::CordicGain;
      end
      ST_ALOAD: begin
        ctl.load = 1'b1;
        if (vec_neg) begin
          a_z0 = pq[33] ? -Half : Half;
          x_load = -40'(pi_);
          y_load = -40'(pq);
        end else begin
          x_load = 40'(pi_);
          y_load = 40'(pq);
        end
        z_load = a_z0;
      end
      ST_NCO1, ST_NCO2: begin
        ctl.step = 1'b1;
        ctl.mode = cpnt_pkg::MODE_ROTATE;
      end
      ST_ATAN: begin
        ctl.step = 1'b1;
        ctl.mode = cpnt_pkg::MODE_VECTOR;
      end
      default: ;
    endcase
    step_f = PB'((acc_a + acc_b + 58'sd32768) >>> 16);
    if (CmpW'(step_f) < CmpW'(low_lim) || CmpW'(step_f) > CmpW'(high_lim)) begin
      limited = PB'(center);
    end else begin
      limited = step_f;
    end
  end

  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      out_valid <= 1'b0;
      coef     <= 16'd62000;
      center   <= '0;
      low_lim  <= -24'sd8388608;
      high_lim <= 24'sd8388607;
      angle    <= '0;
      run_step <= '0;
    end else begin
      // In the final state the output register is reloaded instead.
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          cpnt_pkg::REG_COEF:   coef <= cfg_data[15:0];
          cpnt_pkg::REG_CENTER: begin
            center   <= cfg_data;
            run_step <= PB'(signed'(cfg_data));
          end
          cpnt_pkg::REG_LOW:    low_lim <= cfg_data;
          cpnt_pkg::REG_HIGH:   high_lim <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          si <= s_axis_tdata[15:0];
          sq <= s_axis_tdata[31:16];
          fold_neg <= fold_n;
          cnt <= '0;
          state <= ST_NCO1;
        end
        ST_NCO1: begin
          cnt <= cnt + 5'd1;
          if (cnt == LastStage) state <= ST_SCALE1;
        end
        ST_SCALE1: begin
          c <= scale_q15(cx, fold_neg);
          s <= scale_q15(cy, fold_neg);
          state <= ST_MIX;
        end
        ST_MIX: begin
          p_a <= 34'(si) * 34'(c);
          p_b <= 34'(sq) * 34'(s);
          p_c <= 34'(sq) * 34'(c);
          p_d <= 34'(si) * 34'(s);
          state <= ST_MIX2;
        end
        ST_MIX2: begin
          pi_ <= p_a + p_b;
          pq  <= p_c - p_d;
          state <= ST_ALOAD;
        end
        ST_ALOAD: begin
          cnt <= '0;
          state <= ST_ATAN;
        end
        ST_ATAN: begin
          cnt <= cnt + 5'd1;
          if (cnt == LastStage) state <= ST_FILT1;
        end
        ST_FILT1: begin
          err <= (pi_ == 0 && pq == 0) ? '0 : cz;
          state <= ST_FILT2;
        end
        ST_FILT2: begin
          acc_a <= (58'sd65536 - 58'(coef)) * 58'(err);
          acc_b <= 58'(coef) * 58'(run_step);
          state <= ST_LIMIT;
        end
        ST_LIMIT: begin
          run_step <= limited;
          fold_neg <= fold_n;
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          angle <= angle + run_step;
          cnt <= '0;
          state <= ST_NCO2;
        end
        ST_NCO2: begin
          cnt <= cnt + 5'd1;
          if (cnt == LastStage) state <= ST_DONE;
        end
        ST_DONE: if (!out_valid || m_axis_tready) begin
          out_valid <= 1'b1;
          out_data  <= {16'(scale_q15(cy, fold_neg)), 16'(scale_q15(cx, fold_neg)),
                        24'(signed'(run_step)), 24'(signed'(err)),
                        round_sat16(pq), round_sat16(pi_)};
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/cpnt_cordic.sv =====
// Shared CORDIC datapath: one microrotation per cycle while ctl.step is set, in rotation or vectoring mode.
module cpnt_cordic #(
  parameter int PHASE_BITS = 24
) (
  input  logic                         clk,
  input  cpnt_pkg::cordic_ctl_t        ctl,
  input  logic signed [39:0]           x_load,
  input  logic signed [39:0]           y_load,
  input  logic signed [PHASE_BITS-1:0] z_load,
  output logic signed [39:0]           x,
  output logic signed [39:0]           y,
  output logic signed [PHASE_BITS-1:0] z
);

  localparam int Shift = 32 - PHASE_BITS;

  logic [32:0]                 atan_round;
  logic signed [PHASE_BITS-1:0] t;
  logic                        up;
  logic signed [39:0]          xs, ys;

  always_comb begin
    if (Shift == 0) begin
      atan_round = {1'b0, cpnt_pkg::atan_turns32(ctl.index)};
    end else begin
      atan_round = ({1'b0, cpnt_pkg::atan_turns32(ctl.index)}
                    + (33'd1 << (Shift - 1))) >> Shift;
    end
    t  = atan_round[PHASE_BITS-1:0];
    xs = x >>> ctl.index;
    ys = y >>> ctl.index;
    if (ctl.mode == cpnt_pkg::MODE_ROTATE) begin
      up = !z[PHASE_BITS-1];
    end else begin
      up = (y <= 0);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x <= x_load;
      y <= y_load;
      z <= z_load;
    end else if (ctl.step) begin
      if (up) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - t;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + t;
      end
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the complex PLL tracker: fixed-point loop predictor and stream scoreboard.
module tb_top;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = cpnt_pkg::REG_COEF;
  logic [23:0] cfg_data = '0;

  typedef struct packed {
    logic [15:0] nco_sin;
    logic [15:0] nco_cos;
    logic [23:0] step_now;
    logic [23:0] phase_error;
    logic [15:0] mixed_q;
    logic [15:0] mixed_i;
  } pll_word_t;

  pll_word_t expected_words[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Predictor state and registers.
  longint beta_q16, center_step, step_lo, step_hi, phase_acc, loop_step;

  complex_pll_nco_tracker uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #40000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint wrap24(longint v);
    logic [23:0] u;
    u = v[23:0];
    return longint'($signed(u));
  endfunction

  function automatic longint atan_unit(int i);
    longint t;
    t = longint'(cpnt_pkg::atan_turns32(5'(i)));
    return (t + 128) >>> 8;
  endfunction

  function automatic longint to_q15(longint x);
    longint r;
    r = shr_floor(x * 32767 + (longint'(1) << 29), 30);
    if (r > 32767) r = 32767;
    if (r < -32767) r = -32767;
    return r;
  endfunction

  task automatic nco_value(input longint ang, output longint c, output longint s);
    longint x, y, z, xn;
    bit flip;
    x = 652032874;
    y = 0;
    flip = 0;
    if (ang > (longint'(1) << 22)) begin
      ang -= longint'(1) << 23;
      flip = 1;
    end else if (ang < -(longint'(1) << 22)) begin
      ang += longint'(1) << 23;
      flip = 1;
    end
    z = ang;
    for (int i = 0; i < 18; i++) begin
      if (z >= 0) begin
        xn = x - shr_floor(y, i); y = y + shr_floor(x, i); z -= atan_unit(i);
      end else begin
        xn = x + shr_floor(y, i); y = y - shr_floor(x, i); z += atan_unit(i);
      end
      x = xn;
    end
    c = to_q15(x);
    s = to_q15(y);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endtask

  function automatic longint vector_angle(longint x, longint y);
    longint z, xn;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? (longint'(1) << 23) : -(longint'(1) << 23);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 18; i++) begin
      if (y > 0) begin
        xn = x + shr_floor(y, i); y = y - shr_floor(x, i); z += atan_unit(i);
      end else begin
        xn = x - shr_floor(y, i); y = y + shr_floor(x, i); z -= atan_unit(i);
      end
      x = xn;
    end
    return wrap24(z);
  endfunction

  function automatic longint round_sat(longint v);
    longint r;
    r = shr_floor(v + 16384, 15);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  task automatic track_sample(input logic [15:0] si_bits, input logic [15:0] sq_bits);
    longint si, sq, c, s, pr, pq, err, acc;
    pll_word_t w;
    si = longint'($signed(si_bits));
    sq = longint'($signed(sq_bits));
    nco_value(phase_acc, c, s);
    pr = si * c + sq * s;
    pq = sq * c - si * s;
    err = vector_angle(pr, pq);
    acc = (65536 - beta_q16) * err + beta_q16 * loop_step;
    loop_step = wrap24(shr_floor(acc + 32768, 16));
    if (loop_step < step_lo || loop_step > step_hi) loop_step = wrap24(center_step);
    phase_acc = wrap24(phase_acc + loop_step);
    nco_value(phase_acc, c, s);
    w.mixed_i = 16'(round_sat(pr));
    w.mixed_q = 16'(round_sat(pq));
    w.phase_error = 24'(err);
    w.step_now = 24'(loop_step);
    w.nco_cos = 16'(c);
    w.nco_sin = 16'(s);
    expected_words.push_back(w);
  endtask

  // The valid line stays up between words unless the sender idles.
  task automatic send_sample(input logic [15:0] si, input logic [15:0] sq);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {sq, si};
    track_sample(si, sq);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Registers are only written once the block has drained.
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      cpnt_pkg::REG_COEF: beta_q16 = longint'(val[15:0]);
      cpnt_pkg::REG_CENTER: begin
        center_step = longint'($signed(val));
        loop_step = center_step;
      end
      cpnt_pkg::REG_LOW: step_lo = longint'($signed(val));
      default: step_hi = longint'($signed(val));
    endcase
  endtask

  always @(posedge clk) begin
    pll_word_t got;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result word %h", got);
        end else begin
          pll_word_t want;
          want = expected_words.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"Mismatch: mixed %h/%h exp %h/%h, err %h exp %h, ",
                        "step %h exp %h, nco %h/%h exp %h/%h"},
                       got.mixed_i, got.mixed_q, want.mixed_i, want.mixed_q,
                       got.phase_error, want.phase_error, got.step_now, want.step_now,
                       got.nco_cos, got.nco_sin, want.nco_cos, want.nco_sin);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic test_extremes();
    logic [15:0] v[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h5555};
    send_sample(16'h0000, 16'h0000);  // zero product gives zero error
    for (int a = 0; a < 6; a++) send_sample(v[a], v[5 - a]);
    for (int a = 0; a < 4; a++) send_sample(v[a], v[a]);
    send_sample(16'h8000, 16'h0000);  // angle exactly a half turn
    send_sample(16'h8000, 16'hffff);
  endtask

  task automatic test_register_extremes();
    write_reg(cpnt_pkg::REG_COEF, 24'd0);
    write_reg(cpnt_pkg::REG_CENTER, 24'h7fffff);
    for (int a = 0; a < 4; a++) send_sample(16'($urandom), 16'($urandom));
    write_reg(cpnt_pkg::REG_COEF, 24'h00ffff);
    write_reg(cpnt_pkg::REG_CENTER, 24'h800000);
    for (int a = 0; a < 4; a++) send_sample(16'($urandom), 16'($urandom));
    // Low above high: every step snaps back to the center.
    write_reg(cpnt_pkg::REG_LOW, 24'd1000);
    write_reg(cpnt_pkg::REG_HIGH, 24'hfff000);
    write_reg(cpnt_pkg::REG_CENTER, 24'd4000);
    for (int a = 0; a < 4; a++) send_sample(16'($urandom), 16'($urandom));
  endtask

  task automatic test_random_tracking();
    int pcts[4][2] = '{'{0, 0}, '{59, 0}, '{0, 59}, '{37, 37}};
    for (int p = 0; p < 4; p++) begin
      write_reg(cpnt_pkg::REG_COEF, 24'($urandom_range(65535)));
      write_reg(cpnt_pkg::REG_CENTER, 24'($signed($urandom_range(400000)) - 200000));
      write_reg(cpnt_pkg::REG_LOW,
                (p == 3) ? 24'h800000 : 24'($signed(-$urandom_range(600000))));
      write_reg(cpnt_pkg::REG_HIGH, (p == 3) ? 24'h7fffff : 24'($urandom_range(600000)));
      send_idle_pct = pcts[p][0];
      recv_stall_pct = pcts[p][1];
      for (int n = 0; n < 110; n++) begin
        int amp, ang;
        logic [15:0] si, sq;
        // Mostly a rotating tone the loop can track, some full-range noise.
        if ($urandom_range(3) == 0) begin
          si = 16'($urandom);
          sq = 16'($urandom);
        end else begin
          amp = $urandom_range(32000, 1000);
          ang = n * 7 + $urandom_range(3);
          si = 16'($rtoi(amp * $cos(ang * 0.05)));
          sq = 16'($rtoi(amp * $sin(ang * 0.05)));
        end
        send_sample(si, sq);
      end
    end
  endtask

  initial begin
    beta_q16 = 62000;
    center_step = 0;
    step_lo = -8388608;
    step_hi = 8388607;
    phase_acc = 0;
    loop_step = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_register_extremes();
    test_random_tracking();
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
